// ----- hw/rtl/clbd_pkg.sv -----
// ----------------------------------------------------------------------------
// clbd_pkg
// shared types and constants of the line binarize and despeckle block
// ----------------------------------------------------------------------------
`default_nettype none

package clbd_pkg;

  localparam int PIX_W    = 8;
  localparam int CNT_W    = 7;
  localparam int LINE_W   = 9;
  localparam int MODE_W   = 2;
  localparam int RROW_W   = 6;
  localparam int RSUM_W   = 14;

  localparam logic [CNT_W-1:0]  NO_ROW   = '1;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_FRAME = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_BIN_RD = 6'b000010,
    S_BIN_WR = 6'b000100,
    S_DSP_RD = 6'b001000,
    S_DSP_WR = 6'b010000,
    S_READ   = 6'b100000
  } state_t;

  typedef struct packed {
    logic load_left;
    logic load_mid;
    logic shift;
  } unit_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/clbd_frame_ram.sv -----
// ----------------------------------------------------------------------------
// clbd_frame_ram
// frame store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module clbd_frame_ram #(
  parameter int DEPTH = 4800,
  parameter int AW    = 13
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [clbd_pkg::PIX_W-1:0]  wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [clbd_pkg::PIX_W-1:0]  rdata
);

  logic [clbd_pkg::PIX_W-1:0] mem [DEPTH];
  logic [clbd_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hw/rtl/clbd_pixel_unit.sv -----
// ----------------------------------------------------------------------------
// clbd_pixel_unit
// shared pixel unit: threshold compare and three-pixel despeckle window
// ----------------------------------------------------------------------------
`default_nettype none

module clbd_pixel_unit (
  input  wire logic                        clk,
  input  wire clbd_pkg::unit_ctrl_t        ctrl,
  input  wire logic [clbd_pkg::PIX_W-1:0]  rdata,
  input  wire logic [clbd_pkg::PIX_W-1:0]  threshold,
  output logic      [clbd_pkg::PIX_W-1:0]  bin_value,
  output logic      [clbd_pkg::PIX_W-1:0]  dsp_value
);

  localparam logic [clbd_pkg::PIX_W-1:0] ZERO = '0;
  localparam logic [clbd_pkg::PIX_W-1:0] ONE  = clbd_pkg::PIX_W'(1);

  logic [clbd_pkg::PIX_W-1:0] left_r;
  logic [clbd_pkg::PIX_W-1:0] mid_r;
  logic [clbd_pkg::PIX_W-1:0] fill_v;

  assign bin_value = (rdata < threshold) ? ZERO : ONE;

  // fill a lone 0, then clear a lone 1
  assign fill_v    = (mid_r == ZERO && left_r == ONE && rdata == ONE) ? ONE : mid_r;
  assign dsp_value = (fill_v == ONE && left_r == ZERO && rdata == ZERO) ? ZERO : fill_v;

  always_ff @(posedge clk) begin
    if (ctrl.load_left) begin
      left_r <= rdata;
    end
    if (ctrl.load_mid) begin
      mid_r <= rdata;
    end
    if (ctrl.shift) begin
      left_r <= dsp_value;
      mid_r  <= rdata;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/camera_line_binarize_despeckle.sv -----
// ----------------------------------------------------------------------------
// camera_line_binarize_despeckle
// frame capture with threshold binarization and lone-pixel removal
// ----------------------------------------------------------------------------
// Frame sync, pixel and most line sync transfers leave the block idle. A line
// sync that binarizes a row, one that despeckles a row and the last pixel of
// the frame start a row pass. A read goes through S_READ, which waits for the
// result register to be free. Row passes step column by column, a read state
// and then a write state per column, through the single port pair of the frame
// store and the shared pixel unit; in_ready is low meanwhile. The frame store
// is not cleared after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_line_binarize_despeckle #(
  parameter int WIDTH  = 80,
  parameter int HEIGHT = 60,
  parameter int LINES  = 480
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [clbd_pkg::MODE_W-1:0]       in_mode,
  input  wire logic [clbd_pkg::PIX_W-1:0]        in_pixel,
  input  wire logic [clbd_pkg::RROW_W-1:0]       in_read_row,
  input  wire logic [clbd_pkg::CNT_W-1:0]        in_read_col,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [clbd_pkg::PIX_W-1:0]        out_read_value,
  output logic                                   out_frame_done,
  output logic      [clbd_pkg::RROW_W-1:0]       out_rows_captured,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [clbd_pkg::PIX_W-1:0]        cfg_data
);

  localparam int DEPTH      = WIDTH * HEIGHT;
  localparam int AW         = $clog2(DEPTH);
  localparam int PERIOD_RAW = LINES / HEIGHT;
  localparam int PERIOD     = (PERIOD_RAW == 0) ? 1 : PERIOD_RAW;
  localparam int PH_W       = $clog2(PERIOD + 1);
  localparam int CW         = clbd_pkg::CNT_W;
  localparam int PW         = clbd_pkg::PIX_W;

  localparam logic [CW-1:0]   WIDTH_C  = CW'(WIDTH);
  localparam logic [CW-1:0]   HEIGHT_C = CW'(HEIGHT);
  localparam logic [PH_W-1:0] PH_LAST  = PH_W'(PERIOD - 1);

  clbd_pkg::state_t            state_r, state_nxt;
  logic [clbd_pkg::LINE_W-1:0] line_cnt_r, line_cnt_nxt;
  logic [PH_W-1:0]             phase_r, phase_nxt;
  logic [CW-1:0]               row_cnt_r, row_cnt_nxt;
  logic [CW-1:0]               cap_col_r, cap_col_nxt;
  logic                        capturing_r, capturing_nxt;
  logic [CW-1:0]               bin_row_r, bin_row_nxt;
  logic                        done_r, done_nxt;
  logic [AW-1:0]               row_base_r, row_base_nxt;
  logic [CW-1:0]               pass_col_r, pass_col_nxt;
  logic [PW-1:0]               thr_r;
  logic                        oor_r, oor_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [PW-1:0]               out_value_r, out_value_nxt;
  logic                        out_done_r, out_done_nxt;
  logic [clbd_pkg::RROW_W-1:0] out_rows_r, out_rows_nxt;

  logic                        accept;
  logic [PH_W-1:0]             ph_step;
  logic [clbd_pkg::RSUM_W-1:0] rd_sum;
  logic                        rd_in_range;
  logic [AW-1:0]               pass_addr;
  logic [AW-1:0]               prev_addr;
  logic [AW-1:0]               cap_addr;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [PW-1:0]               mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [PW-1:0]               mem_rdata;

  clbd_pkg::unit_ctrl_t        unit_ctrl;
  logic [PW-1:0]               bin_value;
  logic [PW-1:0]               dsp_value;

  assign accept    = in_valid & in_ready;
  assign in_ready  = (state_r == clbd_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  assign ph_step   = (line_cnt_r == clbd_pkg::LINE_MAX || phase_r == PH_LAST) ?
                     '0 : PH_W'(phase_r + 1'b1);
  assign rd_sum    = clbd_pkg::RSUM_W'(in_read_row) * clbd_pkg::RSUM_W'(WIDTH)
                   + clbd_pkg::RSUM_W'(in_read_col);
  assign rd_in_range = ({1'b0, in_read_row} < HEIGHT_C) && (in_read_col < WIDTH_C);
  assign pass_addr = row_base_r + AW'(pass_col_r);
  assign prev_addr = row_base_r + AW'(pass_col_r - 1'b1);
  assign cap_addr  = row_base_r + AW'(cap_col_r);

  always_comb begin
    state_nxt     = state_r;
    line_cnt_nxt  = line_cnt_r;
    phase_nxt     = phase_r;
    row_cnt_nxt   = row_cnt_r;
    cap_col_nxt   = cap_col_r;
    capturing_nxt = capturing_r;
    bin_row_nxt   = bin_row_r;
    done_nxt      = done_r;
    row_base_nxt  = row_base_r;
    pass_col_nxt  = pass_col_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_value_nxt = out_value_r;
    out_done_nxt  = out_done_r;
    out_rows_nxt  = out_rows_r;
    mem_we        = 1'b0;
    mem_waddr     = pass_addr;
    mem_wdata     = bin_value;
    mem_re        = 1'b0;
    mem_raddr     = pass_addr;
    unit_ctrl     = '0;

    case (state_r)
      clbd_pkg::S_IDLE: begin
        if (accept) begin
          case (in_mode)
            clbd_pkg::MODE_FRAME: begin
              line_cnt_nxt  = '0;
              phase_nxt     = '0;
              row_cnt_nxt   = '0;
              cap_col_nxt   = '0;
              capturing_nxt = 1'b0;
              bin_row_nxt   = clbd_pkg::NO_ROW;
              done_nxt      = 1'b0;
            end
            clbd_pkg::MODE_LINE: begin
              if (!done_r) begin
                line_cnt_nxt = line_cnt_r + 1'b1;
                phase_nxt    = ph_step;
                if (ph_step == '0 && row_cnt_r < HEIGHT_C) begin
                  capturing_nxt = 1'b1;
                  cap_col_nxt   = '0;
                  row_cnt_nxt   = row_cnt_r + 1'b1;
                  row_base_nxt  = (row_cnt_r == '0) ? '0 : row_base_r + AW'(WIDTH);
                end else if (row_cnt_r != '0) begin
                  pass_col_nxt = '0;
                  if (bin_row_r != row_cnt_r - 1'b1) begin
                    bin_row_nxt = row_cnt_r - 1'b1;
                    state_nxt   = clbd_pkg::S_BIN_RD;
                  end else begin
                    state_nxt   = clbd_pkg::S_DSP_RD;
                  end
                end
              end
            end
            clbd_pkg::MODE_PIXEL: begin
              if (!capturing_r || row_cnt_r == '0 || cap_col_r >= WIDTH_C) begin
                capturing_nxt = 1'b0;
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = cap_addr;
                mem_wdata   = in_pixel;
                cap_col_nxt = cap_col_r + 1'b1;
                if (cap_col_r == WIDTH_C - 1'b1) begin
                  capturing_nxt = 1'b0;
                  if (row_cnt_r == HEIGHT_C) begin
                    bin_row_nxt  = HEIGHT_C - 1'b1;
                    done_nxt     = 1'b1;
                    pass_col_nxt = '0;
                    state_nxt    = clbd_pkg::S_BIN_RD;
                  end
                end
              end
            end
            default: begin
              oor_nxt   = !rd_in_range;
              mem_re    = 1'b1;
              mem_raddr = rd_sum[AW-1:0];
              state_nxt = clbd_pkg::S_READ;
            end
          endcase
        end
      end
      clbd_pkg::S_BIN_RD: begin
        mem_re    = 1'b1;
        state_nxt = clbd_pkg::S_BIN_WR;
      end
      clbd_pkg::S_BIN_WR: begin
        mem_we = 1'b1;
        if (pass_col_r == WIDTH_C - 1'b1) begin
          state_nxt = clbd_pkg::S_IDLE;
        end else begin
          pass_col_nxt = pass_col_r + 1'b1;
          state_nxt    = clbd_pkg::S_BIN_RD;
        end
      end
      clbd_pkg::S_DSP_RD: begin
        mem_re    = 1'b1;
        state_nxt = clbd_pkg::S_DSP_WR;
      end
      clbd_pkg::S_DSP_WR: begin
        if (pass_col_r == '0) begin
          unit_ctrl.load_left = 1'b1;
          pass_col_nxt        = pass_col_r + 1'b1;
          state_nxt           = clbd_pkg::S_DSP_RD;
        end else if (pass_col_r == CW'(1)) begin
          unit_ctrl.load_mid = 1'b1;
          pass_col_nxt       = pass_col_r + 1'b1;
          state_nxt          = clbd_pkg::S_DSP_RD;
        end else begin
          // window right edge just read, write back the middle pixel
          unit_ctrl.shift = 1'b1;
          mem_we          = 1'b1;
          mem_waddr       = prev_addr;
          mem_wdata       = dsp_value;
          if (pass_col_r == WIDTH_C - CW'(2)) begin
            state_nxt = clbd_pkg::S_IDLE;
          end else begin
            pass_col_nxt = pass_col_r + 1'b1;
            state_nxt    = clbd_pkg::S_DSP_RD;
          end
        end
      end
      clbd_pkg::S_READ: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = oor_r ? '0 : mem_rdata;
          out_done_nxt  = done_r;
          out_rows_nxt  = row_cnt_r[clbd_pkg::RROW_W-1:0];
          state_nxt     = clbd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = clbd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clbd_pkg::S_IDLE;
      line_cnt_r  <= '0;
      phase_r     <= '0;
      row_cnt_r   <= '0;
      cap_col_r   <= '0;
      capturing_r <= 1'b0;
      bin_row_r   <= clbd_pkg::NO_ROW;
      done_r      <= 1'b0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      line_cnt_r  <= line_cnt_nxt;
      phase_r     <= phase_nxt;
      row_cnt_r   <= row_cnt_nxt;
      cap_col_r   <= cap_col_nxt;
      capturing_r <= capturing_nxt;
      bin_row_r   <= bin_row_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_base_r  <= row_base_nxt;
    pass_col_r  <= pass_col_nxt;
    oor_r       <= oor_nxt;
    out_value_r <= out_value_nxt;
    out_done_r  <= out_done_nxt;
    out_rows_r  <= out_rows_nxt;
  end

  clbd_frame_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  clbd_pixel_unit u_unit (
    .clk       (clk),
    .ctrl      (unit_ctrl),
    .rdata     (mem_rdata),
    .threshold (thr_r),
    .bin_value (bin_value),
    .dsp_value (dsp_value)
  );

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_value_r;
  assign out_frame_done    = out_done_r;
  assign out_rows_captured = out_rows_r;

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_cnt_r <= HEIGHT_C)
    else $error("row count beyond frame height");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cap_col_r <= WIDTH_C)
    else $error("capture column beyond row width");

  a_done_rows: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (row_cnt_r == HEIGHT_C && !capturing_r))
    else $error("frame done with rows outstanding");

  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == clbd_pkg::S_READ))
    else $error("result raised outside a read");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench: event model of the frame store, random gaps and stalls
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import clbd_pkg::*;

  localparam int WIDTH         = 80;
  localparam int HEIGHT        = 60;
  localparam int LINES         = 480;
  localparam int PERIOD        = (LINES / HEIGHT == 0) ? 1 : LINES / HEIGHT;
  localparam int ROWS_FILLED   = 4;
  localparam int SETTLE_CYCLES = 2 * WIDTH + 16;
  localparam int STALL_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 10;
  localparam int ROW_TOP       = (1 << RROW_W) - 1;
  localparam int COL_TOP       = (1 << CNT_W) - 1;

  typedef struct packed {
    logic [PIX_W-1:0]  value;
    logic              done;
    logic [RROW_W-1:0] rows;
  } read_reply_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [MODE_W-1:0] in_mode     = MODE_FRAME;
  logic [PIX_W-1:0]  in_pixel    = '0;
  logic [RROW_W-1:0] in_read_row = '0;
  logic [CNT_W-1:0]  in_read_col = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [PIX_W-1:0]  out_read_value;
  logic              out_frame_done;
  logic [RROW_W-1:0] out_rows_captured;
  logic              cfg_valid   = 1'b0;
  logic              cfg_ready;
  logic [PIX_W-1:0]  cfg_data    = '0;

  // frame model
  logic [PIX_W-1:0]  pix_store [WIDTH*HEIGHT];
  logic [LINE_W-1:0] line_cnt       = '0;
  logic [CNT_W-1:0]  rows_started   = '0;
  logic [CNT_W-1:0]  fill_col       = '0;
  logic              filling        = 1'b0;
  logic [CNT_W-1:0]  marked_row     = NO_ROW;
  logic              frame_complete = 1'b0;
  logic [PIX_W-1:0]  thresh         = '0;
  // rows below this index have been filled completely at least once
  int unsigned       rows_stored    = 0;

  read_reply_t pending_reads [$];
  read_reply_t got_reply;
  read_reply_t want_reply;
  int unsigned n_errors     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned calm_items   = 0;
  int unsigned ready_hold   = 0;
  int unsigned ready_calm   = 0;
  int unsigned ready_roll;

  camera_line_binarize_despeckle #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT),
    .LINES  (LINES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_pixel          (in_pixel),
    .in_read_row       (in_read_row),
    .in_read_col       (in_read_col),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_value    (out_read_value),
    .out_frame_done    (out_frame_done),
    .out_rows_captured (out_rows_captured),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void threshold_row(int r);
    for (int c = 0; c < WIDTH; c++)
      pix_store[r*WIDTH+c] = (pix_store[r*WIDTH+c] < thresh) ? 8'd0 : 8'd1;
    marked_row = CNT_W'(r);
  endfunction

  function automatic void predict_camera_event(logic [MODE_W-1:0] mode,
                                               logic [PIX_W-1:0] pix,
                                               logic [RROW_W-1:0] rrow,
                                               logic [CNT_W-1:0] rcol);
    int r;
    int base;
    read_reply_t reply;
    case (mode)
      MODE_FRAME: begin
        line_cnt       = '0;
        rows_started   = '0;
        fill_col       = '0;
        filling        = 1'b0;
        marked_row     = NO_ROW;
        frame_complete = 1'b0;
      end
      MODE_LINE: begin
        if (!frame_complete) begin
          line_cnt = line_cnt + 1'b1;
          if (int'(line_cnt) % PERIOD == 0 && rows_started < HEIGHT) begin
            filling      = 1'b1;
            fill_col     = '0;
            rows_started = rows_started + 1'b1;
          end else if (rows_started != 0 && rows_started <= HEIGHT) begin
            r = int'(rows_started) - 1;
            if (marked_row != CNT_W'(r)) begin
              threshold_row(r);
            end else begin
              // in-place pass: fill a lone 0, then clear a lone 1
              base = r * WIDTH;
              for (int c = 1; c + 2 < WIDTH; c++) begin
                if (pix_store[base+c] == 0 && pix_store[base+c-1] == 1 &&
                    pix_store[base+c+1] == 1)
                  pix_store[base+c] = 8'd1;
                if (pix_store[base+c] == 1 && pix_store[base+c-1] == 0 &&
                    pix_store[base+c+1] == 0)
                  pix_store[base+c] = 8'd0;
              end
            end
          end
        end
      end
      MODE_PIXEL: begin
        if (!filling || rows_started == 0 || rows_started > HEIGHT || fill_col >= WIDTH) begin
          filling = 1'b0;
        end else begin
          pix_store[(int'(rows_started) - 1) * WIDTH + int'(fill_col)] = pix;
          fill_col = fill_col + 1'b1;
          if (fill_col >= WIDTH) begin
            filling = 1'b0;
            if (int'(rows_started) - 1 == int'(rows_stored))
              rows_stored++;
            if (rows_started == HEIGHT) begin
              threshold_row(HEIGHT - 1);
              frame_complete = 1'b1;
            end
          end
        end
      end
      default: begin
        reply.value = (rrow < HEIGHT && rcol < WIDTH) ?
                      pix_store[int'(rrow) * WIDTH + int'(rcol)] : '0;
        reply.done  = frame_complete;
        reply.rows  = rows_started[RROW_W-1:0];
        pending_reads.push_back(reply);
      end
    endcase
  endfunction

  // a line sync may only open or work on rows already filled once
  function automatic bit line_in_contract();
    return frame_complete || (int'(line_cnt) + 1 < PERIOD * (int'(rows_stored) + 1));
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return thresh;
      3:       return thresh - 1'b1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [MODE_W-1:0] mode, logic [PIX_W-1:0] pix,
                           logic [RROW_W-1:0] rrow, logic [CNT_W-1:0] rcol);
    int unsigned roll;
    int unsigned gap;
    gap = 0;
    if (calm_items != 0) begin
      calm_items--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 2)
        calm_items = $urandom_range(20, 120);
      else if (roll >= 96)
        gap = $urandom_range(8, 40);
      else if (roll >= 70)
        gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_pixel    <= pix;
    in_read_row <= rrow;
    in_read_col <= rcol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_camera_event(mode, pix, rrow, rcol);
  endtask

  task automatic send_line();
    if (line_in_contract())
      send_item(MODE_LINE, PIX_W'($urandom), RROW_W'($urandom), CNT_W'($urandom));
    else
      send_item(MODE_FRAME, PIX_W'($urandom), RROW_W'($urandom), CNT_W'($urandom));
  endtask

  task automatic read_any();
    logic [RROW_W-1:0] r;
    logic [CNT_W-1:0]  c;
    r = ($urandom_range(0, 9) == 0 || rows_stored == 0) ?
        RROW_W'($urandom_range(HEIGHT, ROW_TOP)) :
        RROW_W'($urandom_range(0, rows_stored - 1));
    c = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(WIDTH, COL_TOP))
                                    : CNT_W'($urandom_range(0, WIDTH - 1));
    send_item(MODE_READ, PIX_W'($urandom), r, c);
  endtask

  task automatic drain(int hold);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (hold) @(posedge clk);
  endtask

  task automatic write_threshold(logic [PIX_W-1:0] value);
    drain(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    thresh = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_before_capture();
    write_threshold(8'd0);
    send_item(MODE_READ, PIX_W'($urandom), RROW_W'(ROW_TOP), CNT_W'(COL_TOP));
    send_item(MODE_READ, PIX_W'($urandom), RROW_W'(HEIGHT), '0);
    send_item(MODE_READ, PIX_W'($urandom), '0, CNT_W'(WIDTH));
    // stray pixels with no row open
    send_item(MODE_PIXEL, '0, RROW_W'($urandom), CNT_W'($urandom));
    send_item(MODE_PIXEL, '1, RROW_W'($urandom), CNT_W'($urandom));
    send_item(MODE_FRAME, PIX_W'($urandom), RROW_W'($urandom), CNT_W'($urandom));
    repeat (PERIOD - 1)
      send_item(MODE_LINE, PIX_W'($urandom), RROW_W'($urandom), CNT_W'($urandom));
    send_item(MODE_READ, PIX_W'($urandom), RROW_W'(ROW_TOP - 1), CNT_W'(42));
    send_item(MODE_FRAME, PIX_W'($urandom), RROW_W'($urandom), CNT_W'($urandom));
    send_item(MODE_READ, PIX_W'($urandom), RROW_W'(HEIGHT + 1), CNT_W'(WIDTH + 5));
  endtask

  task automatic test_first_rows();
    write_threshold(PIX_W'($urandom_range(64, 192)));
    send_item(MODE_FRAME, PIX_W'($urandom), RROW_W'($urandom), CNT_W'($urandom));
    for (int k = 0; k < ROWS_FILLED; k++) begin
      repeat (PERIOD - 1)
        send_item(MODE_LINE, PIX_W'($urandom), RROW_W'($urandom), CNT_W'($urandom));
      if (k > 0)
        read_any();
      if (k == ROWS_FILLED / 2)
        drain(0);
      send_item(MODE_LINE, PIX_W'($urandom), RROW_W'($urandom), CNT_W'($urandom));
      repeat (WIDTH)
        send_item(MODE_PIXEL, pick_pixel(), RROW_W'($urandom), CNT_W'($urandom));
    end
    // trailing lines binarize and then despeckle the last row
    for (int n = 0; n < PERIOD - 1; n++) begin
      send_item(MODE_LINE, PIX_W'($urandom), RROW_W'($urandom), CNT_W'($urandom));
      send_item(MODE_READ, PIX_W'($urandom), RROW_W'(ROWS_FILLED - 1),
                CNT_W'($urandom_range(0, WIDTH - 1)));
    end
    send_item(MODE_FRAME, PIX_W'($urandom), RROW_W'($urandom), CNT_W'($urandom));
    read_any();
  endtask

  task automatic test_random_traffic();
    int unsigned roll;
    for (int p = 0; p < 3; p++) begin
      write_threshold((p == 0) ? 8'd255 : (p == 1) ? 8'd0 : PIX_W'($urandom));
      for (int n = 0; n < 22; n++) begin
        if (p == 1 && n == 11)
          drain(0);
        roll = $urandom_range(0, 99);
        if (filling) begin
          if (roll < 88)
            send_item(MODE_PIXEL, pick_pixel(), RROW_W'($urandom), CNT_W'($urandom));
          else if (roll < 92)
            send_line();
          else if (roll < 98)
            read_any();
          else
            send_item(MODE_FRAME, PIX_W'($urandom), RROW_W'($urandom), CNT_W'($urandom));
        end else begin
          if (roll < 58)
            send_line();
          else if (roll < 90)
            read_any();
          else if (roll < 97)
            send_item(MODE_PIXEL, pick_pixel(), RROW_W'($urandom), CNT_W'($urandom));
          else
            send_item(MODE_FRAME, PIX_W'($urandom), RROW_W'($urandom), CNT_W'($urandom));
        end
      end
    end
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    ready_roll = $urandom_range(0, 99);
    if (ready_calm != 0) begin
      ready_calm--;
      out_ready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (ready_roll < 2) begin
      ready_calm = $urandom_range(30, 200);
      out_ready <= 1'b1;
    end else if (ready_roll < 5) begin
      ready_hold = $urandom_range(10, 40);
      out_ready <= 1'b0;
    end else begin
      out_ready <= (ready_roll >= 25);
    end
  end

  // read reply check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_reply.value = out_read_value;
      got_reply.done  = out_frame_done;
      got_reply.rows  = out_rows_captured;
      if (pending_reads.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("unexpected read transfer: value %0d done %0b rows %0d",
                   got_reply.value, got_reply.done, got_reply.rows);
      end else begin
        want_reply = pending_reads.pop_front();
        if (got_reply.value !== want_reply.value || got_reply.done !== want_reply.done ||
            got_reply.rows !== want_reply.rows) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("read mismatch: value %0d/%0d done %0b/%0b rows %0d/%0d (exp/act)",
                     want_reply.value, got_reply.value, want_reply.done, got_reply.done,
                     want_reply.rows, got_reply.rows);
        end
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_before_capture();
    test_first_rows();
    test_random_traffic();
    drain(SETTLE_CYCLES);
    if (n_errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- camera_line_binarize_despeckle.f -----
hw/rtl/clbd_pkg.sv
hw/rtl/clbd_frame_ram.sv
hw/rtl/clbd_pixel_unit.sv
hw/rtl/camera_line_binarize_despeckle.sv
sim/tb_top.sv
